// ===== design/rdcw_pkg.sv =====
// Shared widths, calendar constants, stage payload types and table lookups.
package rdcw_pkg;

  // Field widths of the input and result items.
  localparam int unsigned DayInW    = 7;
  localparam int unsigned MonthInW  = 7;
  localparam int unsigned YearInW   = 14;
  localparam int unsigned HourInW   = 7;
  localparam int unsigned MinuteInW = 7;
  localparam int unsigned SecondInW = 7;

  localparam int unsigned DayOutW    = 5;
  localparam int unsigned MonthOutW  = 4;
  localparam int unsigned YearOffW   = 8;
  localparam int unsigned HourOutW   = 5;
  localparam int unsigned MinuteOutW = 6;
  localparam int unsigned SecondOutW = 6;
  localparam int unsigned WeekdayW   = 3;

  // Width of a full calendar year inside the clamped range, and of the weekday sum.
  localparam int unsigned YearW = 12;
  localparam int unsigned SumW  = 12;

  // Calendar limits.
  localparam logic [YearInW-1:0]    YearMin   = YearInW'(1970);
  localparam logic [YearInW-1:0]    YearMax   = YearInW'(2222);
  localparam logic [YearOffW-1:0]   YearOffMax = YearOffW'(2222 - 1970);
  localparam logic [MonthOutW-1:0]  MonthMin  = MonthOutW'(1);
  localparam logic [MonthOutW-1:0]  MonthMax  = MonthOutW'(12);
  localparam logic [HourOutW-1:0]   HourMax   = HourOutW'(23);
  localparam logic [MinuteOutW-1:0] MinuteMax = MinuteOutW'(59);
  localparam logic [SecondOutW-1:0] SecondMax = SecondOutW'(59);

  // Bit i set means month i+1 has 31 days.
  localparam logic [11:0] LongMonths = 12'hAD5;

  // Century boundaries that fall inside the clamped year range.
  localparam logic [YearW-1:0] Year2000 = YearW'(2000);
  localparam logic [YearW-1:0] Year2100 = YearW'(2100);
  localparam logic [YearW-1:0] Year2200 = YearW'(2200);
  localparam logic [YearW-1:0] YearBase = YearW'(1970);

  // Raw item as it arrives on the input channel.
  typedef struct packed {
    logic [DayInW-1:0]    day;
    logic [MonthInW-1:0]  month;
    logic [YearInW-1:0]   year;
    logic [HourInW-1:0]   hour;
    logic [MinuteInW-1:0] minute;
    logic [SecondInW-1:0] second;
  } raw_t;

  // After the range clamps; day is still raw, its limit needs the month length.
  typedef struct packed {
    logic [DayInW-1:0]     day;
    logic [MonthOutW-1:0]  month;
    logic [YearOffW-1:0]   year_off;
    logic [HourOutW-1:0]   hour;
    logic [MinuteOutW-1:0] minute;
    logic [SecondOutW-1:0] second;
  } clamp_t;

  // After the day clamp, with the year and month part of the weekday sum.
  typedef struct packed {
    logic [DayOutW-1:0]    day;
    logic [MonthOutW-1:0]  month;
    logic [YearOffW-1:0]   year_off;
    logic [HourOutW-1:0]   hour;
    logic [MinuteOutW-1:0] minute;
    logic [SecondOutW-1:0] second;
    logic [SumW-1:0]       part_sum;
  } dated_t;

  // Finished result item.
  typedef struct packed {
    logic [DayOutW-1:0]    day;
    logic [MonthOutW-1:0]  month;
    logic [YearOffW-1:0]   year_off;
    logic [HourOutW-1:0]   hour;
    logic [MinuteOutW-1:0] minute;
    logic [SecondOutW-1:0] second;
    logic [WeekdayW-1:0]   weekday;
  } result_t;

  // Month offsets of the weekday method, month given as 1..12.
  function automatic logic [2:0] month_offset(input logic [MonthOutW-1:0] month);
    logic [2:0] offs;
    unique case (month)
      4'd1:    offs = 3'd0;
      4'd2:    offs = 3'd3;
      4'd3:    offs = 3'd2;
      4'd4:    offs = 3'd5;
      4'd5:    offs = 3'd0;
      4'd6:    offs = 3'd3;
      4'd7:    offs = 3'd5;
      4'd8:    offs = 3'd1;
      4'd9:    offs = 3'd4;
      4'd10:   offs = 3'd6;
      4'd11:   offs = 3'd2;
      4'd12:   offs = 3'd4;
      default: offs = 3'd0;
    endcase
    return offs;
  endfunction

endpackage

// ===== design/rdcw_ifs.sv =====
// Valid/ready channel interfaces for raw dates in and clamped dates out.
interface rdcw_in_if;
  logic                            valid;
  logic                            ready;
  logic [rdcw_pkg::DayInW-1:0]     day_in;
  logic [rdcw_pkg::MonthInW-1:0]   month_in;
  logic [rdcw_pkg::YearInW-1:0]    year_in;
  logic [rdcw_pkg::HourInW-1:0]    hour_in;
  logic [rdcw_pkg::MinuteInW-1:0]  minute_in;
  logic [rdcw_pkg::SecondInW-1:0]  second_in;

  modport source (
    output valid, day_in, month_in, year_in, hour_in, minute_in, second_in,
    input  ready
  );
  modport sink (
    input  valid, day_in, month_in, year_in, hour_in, minute_in, second_in,
    output ready
  );
  modport monitor (
    input valid, ready, day_in, month_in, year_in, hour_in, minute_in, second_in
  );
endinterface

interface rdcw_out_if;
  logic                             valid;
  logic                             ready;
  logic [rdcw_pkg::DayOutW-1:0]     day_out;
  logic [rdcw_pkg::MonthOutW-1:0]   month_out;
  logic [rdcw_pkg::YearOffW-1:0]    year_offset;
  logic [rdcw_pkg::HourOutW-1:0]    hour_out;
  logic [rdcw_pkg::MinuteOutW-1:0]  minute_out;
  logic [rdcw_pkg::SecondOutW-1:0]  second_out;
  logic [rdcw_pkg::WeekdayW-1:0]    weekday;

  modport source (
    output valid, day_out, month_out, year_offset, hour_out, minute_out, second_out,
           weekday,
    input  ready
  );
  modport sink (
    input  valid, day_out, month_out, year_offset, hour_out, minute_out, second_out,
           weekday,
    output ready
  );
  modport monitor (
    input valid, ready, day_out, month_out, year_offset, hour_out, minute_out,
          second_out, weekday
  );
endinterface

// ===== design/rdcw_clamp.sv =====
// First pipeline stage: range clamps of year, month, hour, minute and second.
module rdcw_clamp (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  rdcw_pkg::raw_t   up_data,
  output logic             valid,
  input  logic             dn_ready,
  output rdcw_pkg::clamp_t data
);

  rdcw_pkg::clamp_t data_next;

  // The stage takes a transfer when it is empty or its content moves on.
  assign up_ready = !valid || dn_ready;

  // Clamp each field to its range.
  always_comb begin
    data_next.day = up_data.day;

    if (up_data.year < rdcw_pkg::YearMin) begin
      data_next.year_off = '0;
    end else if (up_data.year > rdcw_pkg::YearMax) begin
      data_next.year_off = rdcw_pkg::YearOffMax;
    end else begin
      data_next.year_off = rdcw_pkg::YearOffW'(up_data.year - rdcw_pkg::YearMin);
    end

    if (up_data.month == '0) begin
      data_next.month = rdcw_pkg::MonthMin;
    end else if (up_data.month > rdcw_pkg::MonthInW'(rdcw_pkg::MonthMax)) begin
      data_next.month = rdcw_pkg::MonthMax;
    end else begin
      data_next.month = up_data.month[rdcw_pkg::MonthOutW-1:0];
    end

    if (up_data.hour > rdcw_pkg::HourInW'(rdcw_pkg::HourMax)) begin
      data_next.hour = rdcw_pkg::HourMax;
    end else begin
      data_next.hour = up_data.hour[rdcw_pkg::HourOutW-1:0];
    end

    if (up_data.minute > rdcw_pkg::MinuteInW'(rdcw_pkg::MinuteMax)) begin
      data_next.minute = rdcw_pkg::MinuteMax;
    end else begin
      data_next.minute = up_data.minute[rdcw_pkg::MinuteOutW-1:0];
    end

    if (up_data.second > rdcw_pkg::SecondInW'(rdcw_pkg::SecondMax)) begin
      data_next.second = rdcw_pkg::SecondMax;
    end else begin
      data_next.second = up_data.second[rdcw_pkg::SecondOutW-1:0];
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== design/rdcw_day.sv =====
// Second pipeline stage: month length, day clamp and the year and month part of the weekday sum.
module rdcw_day (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  rdcw_pkg::clamp_t up_data,
  output logic             valid,
  input  logic             dn_ready,
  output rdcw_pkg::dated_t data
);

  logic [rdcw_pkg::YearW-1:0]     year;
  logic [rdcw_pkg::YearW-1:0]     year_adj;
  logic                           early;
  logic                           leap;
  logic [3:0]                     month_idx;
  logic [rdcw_pkg::DayOutW-1:0]   month_len;
  logic [rdcw_pkg::DayOutW-1:0]   centuries;
  logic [rdcw_pkg::DayOutW-1:0]   quads;
  rdcw_pkg::dated_t               data_next;

  assign up_ready = !valid || dn_ready;

  // Full year and the year the weekday method counts from (January and February
  // belong to the previous year).
  assign year     = rdcw_pkg::YearBase + rdcw_pkg::YearW'(up_data.year_off);
  assign early    = up_data.month < 4'd3;
  assign year_adj = year - rdcw_pkg::YearW'(early);

  // Gregorian leap rule; inside the clamped range the only centuries are
  // 2000 (leap), 2100 and 2200 (not leap).
  assign leap = (year[1:0] == 2'b00) &&
                (year != rdcw_pkg::Year2100) && (year != rdcw_pkg::Year2200);

  // Days in the clamped month.
  assign month_idx = up_data.month - 4'd1;
  always_comb begin
    if (month_idx == 4'd1) begin
      month_len = rdcw_pkg::DayOutW'(28) + rdcw_pkg::DayOutW'(leap);
    end else begin
      month_len = rdcw_pkg::DayOutW'(30) +
                  rdcw_pkg::DayOutW'(rdcw_pkg::LongMonths[month_idx]);
    end
  end

  // Whole centuries and whole 400-year periods of the adjusted year.
  always_comb begin
    if (year_adj >= rdcw_pkg::Year2200) begin
      centuries = rdcw_pkg::DayOutW'(22);
    end else if (year_adj >= rdcw_pkg::Year2100) begin
      centuries = rdcw_pkg::DayOutW'(21);
    end else if (year_adj >= rdcw_pkg::Year2000) begin
      centuries = rdcw_pkg::DayOutW'(20);
    end else begin
      centuries = rdcw_pkg::DayOutW'(19);
    end
    quads = (year_adj >= rdcw_pkg::Year2000) ? rdcw_pkg::DayOutW'(5) : rdcw_pkg::DayOutW'(4);
  end

  // Day clamp and the part of the weekday sum that does not depend on the day.
  always_comb begin
    data_next.month    = up_data.month;
    data_next.year_off = up_data.year_off;
    data_next.hour     = up_data.hour;
    data_next.minute   = up_data.minute;
    data_next.second   = up_data.second;

    if (up_data.day == '0) begin
      data_next.day = rdcw_pkg::DayOutW'(1);
    end else if (up_data.day > rdcw_pkg::DayInW'(month_len)) begin
      data_next.day = month_len;
    end else begin
      data_next.day = up_data.day[rdcw_pkg::DayOutW-1:0];
    end

    data_next.part_sum = rdcw_pkg::SumW'(year_adj) +
                         rdcw_pkg::SumW'(year_adj[rdcw_pkg::YearW-1:2]) +
                         rdcw_pkg::SumW'(quads) -
                         rdcw_pkg::SumW'(centuries) +
                         rdcw_pkg::SumW'(rdcw_pkg::month_offset(up_data.month));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== design/rdcw_wday.sv =====
// Third pipeline stage: adds the day and reduces the sum modulo seven into the result register.
module rdcw_wday (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  rdcw_pkg::dated_t  up_data,
  output logic              valid,
  input  logic              dn_ready,
  output rdcw_pkg::result_t data
);

  logic [rdcw_pkg::SumW-1:0] sum_m1;
  logic [4:0]                fold1;
  logic [3:0]                fold2;
  logic [2:0]                rem;
  rdcw_pkg::result_t         data_next;

  assign up_ready = !valid || dn_ready;

  // Full sum minus one; the sum is always at least one.
  assign sum_m1 = up_data.part_sum + rdcw_pkg::SumW'(up_data.day) - rdcw_pkg::SumW'(1);

  // Eight is one more than seven, so adding the octal digits keeps the residue.
  assign fold1 = 5'(sum_m1[2:0]) + 5'(sum_m1[5:3]) + 5'(sum_m1[8:6]) + 5'(sum_m1[11:9]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
  assign rem   = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  always_comb begin
    data_next.day      = up_data.day;
    data_next.month    = up_data.month;
    data_next.year_off = up_data.year_off;
    data_next.hour     = up_data.hour;
    data_next.minute   = up_data.minute;
    data_next.second   = up_data.second;
    data_next.weekday  = rem + 3'd1;
  end

  // Result register; it holds a finished item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== design/rtc_date_clamp_weekday.sv =====
// Top level of the date clamp and weekday pipeline.
//
//   Channel  Dir  Handshake     Payload
//   req      in   valid/ready   day_in, month_in, year_in, hour_in, minute_in, second_in
//   res      out  valid/ready   day_out, month_out, year_offset, hour_out, minute_out,
//                               second_out, weekday
//
// One item per cycle while the sink does not stall the result channel.
// The three stages (range clamps, day clamp, weekday residue) each hold one item.
// Reset empties all stages; no item is lost or repeated across a stall.
// A stage accepts whenever it is empty or its item moves on, so bubbles close up.
module rtc_date_clamp_weekday (
  input  logic            clk,
  input  logic            rst,
  rdcw_in_if.sink         req,
  rdcw_out_if.source      res
);

  rdcw_pkg::raw_t    raw;
  rdcw_pkg::clamp_t  clamp_data;
  rdcw_pkg::dated_t  dated_data;
  rdcw_pkg::result_t result_data;
  logic              clamp_valid;
  logic              clamp_ready;
  logic              dated_valid;
  logic              dated_ready;

  assign raw.day    = req.day_in;
  assign raw.month  = req.month_in;
  assign raw.year   = req.year_in;
  assign raw.hour   = req.hour_in;
  assign raw.minute = req.minute_in;
  assign raw.second = req.second_in;

  rdcw_clamp u_clamp (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req.valid),
    .up_ready (req.ready),
    .up_data  (raw),
    .valid    (clamp_valid),
    .dn_ready (clamp_ready),
    .data     (clamp_data)
  );

  rdcw_day u_day (
    .clk      (clk),
    .rst      (rst),
    .up_valid (clamp_valid),
    .up_ready (clamp_ready),
    .up_data  (clamp_data),
    .valid    (dated_valid),
    .dn_ready (dated_ready),
    .data     (dated_data)
  );

  rdcw_wday u_wday (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dated_valid),
    .up_ready (dated_ready),
    .up_data  (dated_data),
    .valid    (res.valid),
    .dn_ready (res.ready),
    .data     (result_data)
  );

  assign res.day_out     = result_data.day;
  assign res.month_out   = result_data.month;
  assign res.year_offset = result_data.year_off;
  assign res.hour_out    = result_data.hour;
  assign res.minute_out  = result_data.minute;
  assign res.second_out  = result_data.second;
  assign res.weekday     = result_data.weekday;

endmodule

// ===== design/rdcw_checker.sv =====
// Port-level checks of the date clamp pipeline, bound to the top level.
module rdcw_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                valid,
  input logic                                ready,
  input logic [rdcw_pkg::DayOutW-1:0]        day_out,
  input logic [rdcw_pkg::MonthOutW-1:0]      month_out,
  input logic [rdcw_pkg::YearOffW-1:0]       year_offset,
  input logic [rdcw_pkg::HourOutW-1:0]       hour_out,
  input logic [rdcw_pkg::MinuteOutW-1:0]     minute_out,
  input logic [rdcw_pkg::SecondOutW-1:0]     second_out,
  input logic [rdcw_pkg::WeekdayW-1:0]       weekday
);

  // A stalled result keeps its weekday, day and month.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(weekday) &&
                        $stable(day_out) && $stable(month_out))
    else $error("stalled result changed");

  // No result is valid right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid after reset");

  // Weekday and date stay in range, and February never goes past the 29th.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> weekday != 3'd0 && day_out != 5'd0 &&
              month_out != 4'd0 && month_out <= 4'd12 &&
              !(month_out == 4'd2 && day_out > 5'd29) &&
              year_offset <= 8'd252)
    else $error("date out of range");

  // Short months never show day 31.
  a_short_month: assert property (@(posedge clk) disable iff (rst)
    valid && (month_out == 4'd4 || month_out == 4'd6 ||
              month_out == 4'd9 || month_out == 4'd11)
      |-> day_out <= 5'd30)
    else $error("day past end of short month");

  // Time of day stays in range.
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59)
    else $error("time out of range");

endmodule

bind rtc_date_clamp_weekday rdcw_checker u_rdcw_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (res.valid),
  .ready       (res.ready),
  .day_out     (res.day_out),
  .month_out   (res.month_out),
  .year_offset (res.year_offset),
  .hour_out    (res.hour_out),
  .minute_out  (res.minute_out),
  .second_out  (res.second_out),
  .weekday     (res.weekday)
);

// ===== tb/rtc_date_clamp_weekday_test.sv =====
// Testbench for the date clamp and weekday pipeline, checked against a local calendar predictor.
`timescale 1ns / 100ps

module rtc_date_clamp_weekday_test;

  // Month offsets of the weekday sum, indexed by month minus one.
  localparam int unsigned WeekdayMonthOffs [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
  localparam int unsigned DrainCycles = 8;

  logic clk;
  logic rst;

  rdcw_in_if  req_ch ();
  rdcw_out_if res_ch ();

  rtc_date_clamp_weekday dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // Dates accepted by the block whose results have not come back yet.
  rdcw_pkg::result_t expected_dates [$];
  int unsigned mismatch_count = 0;
  int unsigned dates_sent = 0;
  int unsigned dates_checked = 0;
  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Known values on every input from time zero.
  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.day_in    = '0;
    req_ch.month_in  = '0;
    req_ch.year_in   = '0;
    req_ch.hour_in   = '0;
    req_ch.minute_in = '0;
    req_ch.second_in = '0;
    res_ch.ready     = 1'b0;
  end

  // Clamps every field and works out the weekday of the clamped date.
  function automatic rdcw_pkg::result_t clamp_and_weekday(input rdcw_pkg::raw_t raw);
    rdcw_pkg::result_t exp_res;
    int unsigned yr;
    int unsigned mon;
    int unsigned dy;
    int unsigned limit;
    int unsigned leap;
    int unsigned yy;
    int unsigned sum;
    yr  = raw.year;
    mon = raw.month;
    dy  = raw.day;
    if (yr < rdcw_pkg::YearMin) yr = rdcw_pkg::YearMin;
    if (yr > rdcw_pkg::YearMax) yr = rdcw_pkg::YearMax;
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    leap = ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 1 : 0;
    if (mon == 2) begin
      limit = 28 + leap;
    end else begin
      limit = 30 + rdcw_pkg::LongMonths[mon - 1];
    end
    if (dy < 1) dy = 1;
    if (dy > limit) dy = limit;
    exp_res.day      = rdcw_pkg::DayOutW'(dy);
    exp_res.month    = rdcw_pkg::MonthOutW'(mon);
    exp_res.year_off = rdcw_pkg::YearOffW'(yr - rdcw_pkg::YearMin);
    exp_res.hour     = (raw.hour > rdcw_pkg::HourMax) ?
                       rdcw_pkg::HourMax : rdcw_pkg::HourOutW'(raw.hour);
    exp_res.minute   = (raw.minute > rdcw_pkg::MinuteMax) ?
                       rdcw_pkg::MinuteMax : rdcw_pkg::MinuteOutW'(raw.minute);
    exp_res.second   = (raw.second > rdcw_pkg::SecondMax) ?
                       rdcw_pkg::SecondMax : rdcw_pkg::SecondOutW'(raw.second);
    // January and February count as months of the previous year.
    yy  = (mon < 3) ? yr - 1 : yr;
    sum = yy + yy / 4 - yy / 100 + yy / 400 + WeekdayMonthOffs[mon - 1] + dy;
    exp_res.weekday = rdcw_pkg::WeekdayW'((sum - 1) % 7 + 1);
    return exp_res;
  endfunction

  function automatic rdcw_pkg::raw_t make_date(input int unsigned dy, input int unsigned mon,
                                               input int unsigned yr, input int unsigned hr,
                                               input int unsigned mi, input int unsigned se);
    rdcw_pkg::raw_t raw;
    raw.day    = rdcw_pkg::DayInW'(dy);
    raw.month  = rdcw_pkg::MonthInW'(mon);
    raw.year   = rdcw_pkg::YearInW'(yr);
    raw.hour   = rdcw_pkg::HourInW'(hr);
    raw.minute = rdcw_pkg::MinuteInW'(mi);
    raw.second = rdcw_pkg::SecondInW'(se);
    return raw;
  endfunction

  // Mostly legal values, with boundaries, values just past them and raw bit patterns.
  function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi,
                                             input int unsigned width);
    int unsigned sel;
    int unsigned top;
    sel = $urandom_range(0, 9);
    top = (1 << width) - 1;
    case (sel)
      6:       return (lo > 0 && $urandom_range(0, 1)) ? lo - 1 : lo;
      7:       return $urandom_range(0, 1) ? hi + 1 : hi;
      8:       return $urandom_range(hi + 1, top);
      9:       return $urandom() & top;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic rdcw_pkg::raw_t random_date();
    return make_date(pick_field(1, 31, rdcw_pkg::DayInW),
                     pick_field(1, 12, rdcw_pkg::MonthInW),
                     pick_field(1970, 2222, rdcw_pkg::YearInW),
                     pick_field(0, 23, rdcw_pkg::HourInW),
                     pick_field(0, 59, rdcw_pkg::MinuteInW),
                     pick_field(0, 59, rdcw_pkg::SecondInW));
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Drives one date and holds it until the transfer; called at a rising edge.
  task automatic send_date(input rdcw_pkg::raw_t raw);
    int unsigned gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.day_in    <= raw.day;
    req_ch.month_in  <= raw.month;
    req_ch.year_in   <= raw.year;
    req_ch.hour_in   <= raw.hour;
    req_ch.minute_in <= raw.minute;
    req_ch.second_in <= raw.second;
    do @(posedge clk); while (!req_ch.ready);
    expected_dates = {expected_dates, clamp_and_weekday(raw)};
    dates_sent++;
  endtask

  // Stops sending and waits until every accepted date has come back.
  task automatic wait_for_all_results();
    req_ch.valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  // Sink side: ready held high for random stretches, dropped in random bursts.
  initial begin
    int unsigned hold;
    @(posedge clk);
    forever begin
      if (sink_stalls && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      hold = $urandom_range(1, 20);
      repeat (hold) @(posedge clk);
    end
  end

  // Each result transfer is compared field by field with the oldest expected date.
  always @(posedge clk) begin
    rdcw_pkg::result_t got;
    rdcw_pkg::result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.day      = res_ch.day_out;
      got.month    = res_ch.month_out;
      got.year_off = res_ch.year_offset;
      got.hour     = res_ch.hour_out;
      got.minute   = res_ch.minute_out;
      got.second   = res_ch.second_out;
      got.weekday  = res_ch.weekday;
      if (expected_dates.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transfer with no date outstanding", $time);
      end else begin
        want = expected_dates.pop_front();
        dates_checked++;
        if (got.day !== want.day) report_mismatch("day_out", got.day, want.day);
        if (got.month !== want.month) report_mismatch("month_out", got.month, want.month);
        if (got.year_off !== want.year_off)
          report_mismatch("year_offset", got.year_off, want.year_off);
        if (got.hour !== want.hour) report_mismatch("hour_out", got.hour, want.hour);
        if (got.minute !== want.minute)
          report_mismatch("minute_out", got.minute, want.minute);
        if (got.second !== want.second)
          report_mismatch("second_out", got.second, want.second);
        if (got.weekday !== want.weekday)
          report_mismatch("weekday", got.weekday, want.weekday);
      end
    end
  end

  // All-zero and all-ones inputs, and exact upper and lower limits.
  task automatic test_field_extremes();
    send_date(make_date(0, 0, 0, 0, 0, 0));
    send_date(make_date(127, 127, 16383, 127, 127, 127));
    send_date(make_date(31, 12, 2222, 23, 59, 59));
    send_date(make_date(1, 1, 1970, 0, 0, 0));
  endtask

  // Years below the range clamp up without wrapping; years above clamp down.
  task automatic test_year_clamp();
    send_date(make_date(15, 6, 1969, 12, 30, 30));
    send_date(make_date(15, 6, 1, 12, 30, 30));
    send_date(make_date(15, 6, 2223, 12, 30, 30));
    send_date(make_date(15, 6, 9999, 12, 30, 30));
  endtask

  // Zero month and day, months past December, day limits and leap years.
  task automatic test_month_and_day_clamp();
    send_date(make_date(0, 5, 2024, 1, 1, 1));
    send_date(make_date(20, 0, 2024, 1, 1, 1));
    send_date(make_date(40, 13, 2024, 1, 1, 1));
    send_date(make_date(31, 4, 2023, 1, 1, 1));
    send_date(make_date(30, 2, 2000, 1, 1, 1));
    send_date(make_date(29, 2, 2100, 1, 1, 1));
    send_date(make_date(30, 2, 2200, 1, 1, 1));
    send_date(make_date(29, 2, 2024, 1, 1, 1));
    send_date(make_date(99, 2, 1800, 1, 1, 1));
  endtask

  // Hour, minute and second just past and far past their limits.
  task automatic test_time_clamp();
    send_date(make_date(10, 10, 2010, 24, 60, 60));
    send_date(make_date(10, 10, 2010, 99, 99, 99));
  endtask

  // Dates on both sides of the March boundary of the weekday sum.
  task automatic test_weekday_cases();
    send_date(make_date(28, 2, 2023, 8, 0, 0));
    send_date(make_date(1, 3, 2023, 8, 0, 0));
    send_date(make_date(1, 1, 2001, 8, 0, 0));
    send_date(make_date(31, 12, 1999, 8, 0, 0));
  endtask

  task automatic test_random_dates(input int unsigned count);
    repeat (count) send_date(random_date());
  endtask

  // A burst of dates, then a full pause until the pipeline has emptied.
  task automatic test_drain_pause();
    repeat (40) send_date(random_date());
    wait_for_all_results();
  endtask

  // Final stretch at full rate on both sides.
  task automatic test_back_to_back(input int unsigned count);
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (count) send_date(random_date());
  endtask

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_year_clamp();
    test_month_and_day_clamp();
    test_time_clamp();
    test_weekday_cases();
    test_random_dates(600);
    test_drain_pause();
    test_random_dates(400);
    test_back_to_back(240);
    wait_for_all_results();
    repeat (DrainCycles) @(posedge clk);
    if (expected_dates.size() != 0) begin
      mismatch_count++;
      $display("%0d dates never came back", expected_dates.size());
    end
    $display("Sent %0d dates and checked %0d results, with random gaps and stalls,",
             dates_sent, dates_checked);
    $display("a full drain pause, and a back-to-back stretch; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("Timeout with %0d dates outstanding", expected_dates.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
